[design/complex_arithmetic_unit_macros.svh]
// Assertion macros used by the complex arithmetic unit top level.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("complex_arithmetic_unit: assertion failed");
`define CAU_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("complex_arithmetic_unit: assertion failed");
`else
`define CAU_ASSERT(lbl, clk, rst, prop)
`define CAU_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[design/cau_pkg.sv]
package cau_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int OP_WIDTH       = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   dz;
      logic   re_neg;
      logic   re_ovf;
      logic   im_neg;
      logic   im_ovf;
   } ctl_type;

endpackage

[design/complex_arithmetic_unit.sv]
// Complex arithmetic unit: add, subtract, multiply, divide or modulus of
// complex operands in signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction).
// Input channel req_*: opcode and operands a, b, taken when req_valid and
// req_ready are both high. Result channel rsp_*: res_real, res_imag and the
// div_by_zero / saturated flags, one result per request, in request order.
// The path runs through operand registers, products and sums, sign and
// magnitude, divider setup, a pipelined restoring divider with a step per
// quotient bit (the integer square root runs bit by bit alongside), and a
// final register for saturation and the output.
// Throughput is one transaction per cycle unless rsp_ready stalls; there is no state between items.
// When the receiver holds rsp_ready low with a result pending, the whole
// pipeline freezes and req_ready drops in the same cycle; nothing is lost
// or repeated. Synchronous reset clears all valid bits, so the pipeline
// comes up empty with rsp_valid low; req_ready stays low while in reset.
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cau_pkg::OP_WIDTH-1:0]  req_opcode,
   input  logic signed [DATA_WIDTH-1:0]  req_a_real,
   input  logic signed [DATA_WIDTH-1:0]  req_a_imag,
   input  logic signed [DATA_WIDTH-1:0]  req_b_real,
   input  logic signed [DATA_WIDTH-1:0]  req_b_imag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]  rsp_res_real,
   output logic signed [DATA_WIDTH-1:0]  rsp_res_imag,
   output logic                          rsp_div_by_zero,
   output logic                          rsp_saturated
);

   localparam int W  = DATA_WIDTH;
   localparam int MW = 2 * W;
   localparam int CW = 3 * W + FRAC_BITS + 2;

   logic              en;
   cau_pkg::ctl_type  chain_ctl    [0:W];
   logic [W-1:0]      chain_re_q   [0:W];
   logic [CW-1:0]     chain_re_rem [0:W];
   logic [W-1:0]      chain_im_q   [0:W];
   logic [CW-1:0]     chain_im_rem [0:W];
   logic [MW-1:0]     chain_den    [0:W];
   logic [W-1:0]      chain_root   [0:W];
   logic [MW-1:0]     chain_sq_rem [0:W];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && !reset;

   cau_front #(.W(W), .F(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_op    (req_opcode),
      .in_ar    (req_a_real),
      .in_ai    (req_a_imag),
      .in_br    (req_b_real),
      .in_bi    (req_b_imag),
      .ctl_o    (chain_ctl[0]),
      .re_q_o   (chain_re_q[0]),
      .re_rem_o (chain_re_rem[0]),
      .im_q_o   (chain_im_q[0]),
      .im_rem_o (chain_im_rem[0]),
      .den_o    (chain_den[0]),
      .sq_rem_o (chain_sq_rem[0])
   );

   assign chain_root[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_step
      cau_div_step #(.W(W), .F(FRAC_BITS), .K(W - 1 - i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_i    (chain_ctl[i]),
         .re_q_i   (chain_re_q[i]),
         .re_rem_i (chain_re_rem[i]),
         .im_q_i   (chain_im_q[i]),
         .im_rem_i (chain_im_rem[i]),
         .den_i    (chain_den[i]),
         .root_i   (chain_root[i]),
         .sq_rem_i (chain_sq_rem[i]),
         .ctl_o    (chain_ctl[i+1]),
         .re_q_o   (chain_re_q[i+1]),
         .re_rem_o (chain_re_rem[i+1]),
         .im_q_o   (chain_im_q[i+1]),
         .im_rem_o (chain_im_rem[i+1]),
         .den_o    (chain_den[i+1]),
         .root_o   (chain_root[i+1]),
         .sq_rem_o (chain_sq_rem[i+1])
      );
   end

   cau_back #(.W(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_i     (chain_ctl[W]),
      .re_q_i    (chain_re_q[W]),
      .im_q_i    (chain_im_q[W]),
      .root_i    (chain_root[W]),
      .out_valid (rsp_valid),
      .out_real  (rsp_res_real),
      .out_imag  (rsp_res_imag),
      .out_dz    (rsp_div_by_zero),
      .out_sat   (rsp_saturated)
   );

   // a frozen pipeline keeps its last stage
   `CAU_ASSERT(a_stall_holds, clock, reset, !en |=> $stable(chain_ctl[W]))
   // divide by zero gives a clean zero result
   `CAU_ASSERT(a_dz_zero, clock, reset, rsp_valid && rsp_div_by_zero |-> rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_saturated)
   `CAU_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid && !chain_ctl[0].valid)

endmodule

[design/cau_front.sv]
module cau_front #(
   parameter int W = cau_pkg::DATA_WIDTH_DEF,
   parameter int F = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [cau_pkg::OP_WIDTH-1:0]  in_op,
   input  logic signed [W-1:0]           in_ar,
   input  logic signed [W-1:0]           in_ai,
   input  logic signed [W-1:0]           in_br,
   input  logic signed [W-1:0]           in_bi,
   output cau_pkg::ctl_type              ctl_o,
   output logic [W-1:0]                  re_q_o,
   output logic [3*W+F+1:0]              re_rem_o,
   output logic [W-1:0]                  im_q_o,
   output logic [3*W+F+1:0]              im_rem_o,
   output logic [2*W-1:0]                den_o,
   output logic [2*W-1:0]                sq_rem_o
);

   localparam int MW = 2 * W;
   localparam int CW = 3 * W + F + 2;
   localparam logic [MW:0] RND = (MW+1)'((64'd1 << F) >> 1);

   typedef struct packed {
      logic          ovf;
      logic [W-1:0]  q;
      logic [CW-1:0] rem;
   } part_type;

   // stage 1: operand registers
   logic                    s1_valid_ff;
   cau_pkg::op_type         s1_op_ff;
   logic signed [W-1:0]     s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   // stage 2: products and exact sums
   logic                    s2_valid_ff;
   cau_pkg::op_type         s2_op_ff;
   logic                    s2_dz_ff;
   logic signed [MW-1:0]    p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [MW-1:0]    p_bbr_ff, p_bbi_ff, p_aar_ff, p_aai_ff;
   logic signed [W:0]       sr_ff, si_ff;
   logic signed [W:0]       sr_in, si_in;

   // stage 3: sign and magnitude
   logic                    s3_valid_ff;
   cau_pkg::op_type         s3_op_ff;
   logic                    s3_dz_ff;
   logic                    re_neg_ff, im_neg_ff;
   logic [MW-1:0]           re_mag_ff, im_mag_ff, den_ff;
   logic signed [MW:0]      re_sum, im_sum, den_sum;

   // stage 4: divider / rounding setup
   cau_pkg::ctl_type        ctl_ff, ctl_in;
   part_type                re_part, im_part;
   logic [W-1:0]            re_q_ff, im_q_ff;
   logic [CW-1:0]           re_rem_ff, im_rem_ff;
   logic [MW-1:0]           den4_ff, sq_rem_ff;

   function automatic logic signed [MW:0] sx(input logic signed [MW-1:0] v);
      sx = $signed({v[MW-1], v});
   endfunction

   function automatic part_type setup(input cau_pkg::op_type op, input logic [MW-1:0] mag,
                                      input logic [MW-1:0] den);
      part_type      p;
      logic [MW:0]   scaled;
      logic [CW-1:0] x;
      p      = '0;
      scaled = ({1'b0, mag} + RND) >> F;
      // 2*N + d, so that floor((2N+d)/2d) rounds half away from zero
      x      = (CW'(mag) << (F + 1)) + CW'(den);
      case (op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            p.ovf = |mag[MW-1:W];
            p.q   = mag[W-1:0];
         end
         cau_pkg::OP_MUL: begin
            p.ovf = |scaled[MW:W];
            p.q   = scaled[W-1:0];
         end
         cau_pkg::OP_DIV: begin
            p.ovf = x >= (CW'(den) << (W + 1));
            p.rem = x;
         end
         default: ;
      endcase
      return p;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         ctl_ff      <= '0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         ctl_ff      <= ctl_in;
      end
   end

   always_comb begin
      if (s1_op_ff == cau_pkg::OP_SUB) begin
         sr_in = $signed({s1_ar_ff[W-1], s1_ar_ff}) - $signed({s1_br_ff[W-1], s1_br_ff});
         si_in = $signed({s1_ai_ff[W-1], s1_ai_ff}) - $signed({s1_bi_ff[W-1], s1_bi_ff});
      end else begin
         sr_in = $signed({s1_ar_ff[W-1], s1_ar_ff}) + $signed({s1_br_ff[W-1], s1_br_ff});
         si_in = $signed({s1_ai_ff[W-1], s1_ai_ff}) + $signed({s1_bi_ff[W-1], s1_bi_ff});
      end
   end

   always_comb begin
      den_sum = sx(p_bbr_ff) + sx(p_bbi_ff);
      case (s2_op_ff)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            re_sum = (MW+1)'(sr_ff);
            im_sum = (MW+1)'(si_ff);
         end
         cau_pkg::OP_MUL: begin
            re_sum = sx(p_rr_ff) - sx(p_ii_ff);
            im_sum = sx(p_ri_ff) + sx(p_ir_ff);
         end
         cau_pkg::OP_DIV: begin
            re_sum = sx(p_rr_ff) + sx(p_ii_ff);
            im_sum = sx(p_ir_ff) - sx(p_ri_ff);
         end
         cau_pkg::OP_MOD: begin
            re_sum = sx(p_aar_ff) + sx(p_aai_ff);
            im_sum = '0;
         end
         default: begin
            re_sum = '0;
            im_sum = '0;
         end
      endcase
   end

   always_comb begin
      re_part       = setup(s3_op_ff, re_mag_ff, den_ff);
      im_part       = setup(s3_op_ff, im_mag_ff, den_ff);
      ctl_in.valid  = s3_valid_ff;
      ctl_in.op     = s3_op_ff;
      ctl_in.dz     = s3_dz_ff;
      ctl_in.re_neg = re_neg_ff;
      ctl_in.re_ovf = re_part.ovf;
      ctl_in.im_neg = im_neg_ff;
      ctl_in.im_ovf = im_part.ovf;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff  <= cau_pkg::op_type'(in_op);
         s1_ar_ff  <= in_ar;
         s1_ai_ff  <= in_ai;
         s1_br_ff  <= in_br;
         s1_bi_ff  <= in_bi;

         s2_op_ff  <= s1_op_ff;
         s2_dz_ff  <= (s1_br_ff == '0) && (s1_bi_ff == '0);
         p_rr_ff   <= s1_ar_ff * s1_br_ff;
         p_ii_ff   <= s1_ai_ff * s1_bi_ff;
         p_ri_ff   <= s1_ar_ff * s1_bi_ff;
         p_ir_ff   <= s1_ai_ff * s1_br_ff;
         p_bbr_ff  <= s1_br_ff * s1_br_ff;
         p_bbi_ff  <= s1_bi_ff * s1_bi_ff;
         p_aar_ff  <= s1_ar_ff * s1_ar_ff;
         p_aai_ff  <= s1_ai_ff * s1_ai_ff;
         sr_ff     <= sr_in;
         si_ff     <= si_in;

         s3_op_ff  <= s2_op_ff;
         s3_dz_ff  <= s2_dz_ff;
         re_neg_ff <= re_sum[MW];
         im_neg_ff <= im_sum[MW];
         re_mag_ff <= re_sum[MW] ? MW'(-re_sum) : MW'(re_sum);
         im_mag_ff <= im_sum[MW] ? MW'(-im_sum) : MW'(im_sum);
         den_ff    <= MW'(den_sum);

         re_q_ff   <= re_part.q;
         re_rem_ff <= re_part.rem;
         im_q_ff   <= im_part.q;
         im_rem_ff <= im_part.rem;
         den4_ff   <= den_ff;
         sq_rem_ff <= re_mag_ff;
      end
   end

   assign ctl_o    = ctl_ff;
   assign re_q_o   = re_q_ff;
   assign re_rem_o = re_rem_ff;
   assign im_q_o   = im_q_ff;
   assign im_rem_o = im_rem_ff;
   assign den_o    = den4_ff;
   assign sq_rem_o = sq_rem_ff;

endmodule

[design/cau_div_step.sv]
module cau_div_step #(
   parameter int W = cau_pkg::DATA_WIDTH_DEF,
   parameter int F = cau_pkg::FRAC_BITS_DEF,
   parameter int K = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cau_pkg::ctl_type  ctl_i,
   input  logic [W-1:0]      re_q_i,
   input  logic [3*W+F+1:0]  re_rem_i,
   input  logic [W-1:0]      im_q_i,
   input  logic [3*W+F+1:0]  im_rem_i,
   input  logic [2*W-1:0]    den_i,
   input  logic [W-1:0]      root_i,
   input  logic [2*W-1:0]    sq_rem_i,
   output cau_pkg::ctl_type  ctl_o,
   output logic [W-1:0]      re_q_o,
   output logic [3*W+F+1:0]  re_rem_o,
   output logic [W-1:0]      im_q_o,
   output logic [3*W+F+1:0]  im_rem_o,
   output logic [2*W-1:0]    den_o,
   output logic [W-1:0]      root_o,
   output logic [2*W-1:0]    sq_rem_o
);

   localparam int MW = 2 * W;
   localparam int CW = 3 * W + F + 2;

   cau_pkg::ctl_type  ctl_ff;
   logic [W-1:0]      re_q_ff, re_q_in, im_q_ff, im_q_in, root_ff, root_in;
   logic [CW-1:0]     re_rem_ff, re_rem_in, im_rem_ff, im_rem_in, dsh;
   logic [MW-1:0]     den_ff, sq_rem_ff, sq_rem_in;
   logic [MW:0]       trial;
   logic              is_div, re_hit, im_hit, sq_hit;

   always_comb begin
      // divisor is 2*den, aligned to quotient bit K
      dsh       = CW'(den_i) << (K + 1);
      is_div    = ctl_i.op == cau_pkg::OP_DIV;
      re_hit    = is_div && !ctl_i.re_ovf && (re_rem_i >= dsh);
      im_hit    = is_div && !ctl_i.im_ovf && (im_rem_i >= dsh);
      re_q_in   = re_q_i;
      im_q_in   = im_q_i;
      re_rem_in = re_rem_i;
      im_rem_in = im_rem_i;
      if (re_hit) begin
         re_q_in[K] = 1'b1;
         re_rem_in  = re_rem_i - dsh;
      end
      if (im_hit) begin
         im_q_in[K] = 1'b1;
         im_rem_in  = im_rem_i - dsh;
      end
      // (r + 2^K)^2 - r^2 = r * 2^(K+1) + 2^(2K)
      trial     = ((MW+1)'(root_i) << (K + 1)) + ((MW+1)'(1) << (2 * K));
      sq_hit    = {1'b0, sq_rem_i} >= trial;
      root_in   = root_i;
      sq_rem_in = sq_rem_i;
      if (sq_hit) begin
         root_in[K] = 1'b1;
         sq_rem_in  = sq_rem_i - trial[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_q_ff   <= re_q_in;
         re_rem_ff <= re_rem_in;
         im_q_ff   <= im_q_in;
         im_rem_ff <= im_rem_in;
         den_ff    <= den_i;
         root_ff   <= root_in;
         sq_rem_ff <= sq_rem_in;
      end
   end

   assign ctl_o    = ctl_ff;
   assign re_q_o   = re_q_ff;
   assign re_rem_o = re_rem_ff;
   assign im_q_o   = im_q_ff;
   assign im_rem_o = im_rem_ff;
   assign den_o    = den_ff;
   assign root_o   = root_ff;
   assign sq_rem_o = sq_rem_ff;

endmodule

[design/cau_back.sv]
module cau_back #(
   parameter int W = cau_pkg::DATA_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cau_pkg::ctl_type    ctl_i,
   input  logic [W-1:0]        re_q_i,
   input  logic [W-1:0]        im_q_i,
   input  logic [W-1:0]        root_i,
   output logic                out_valid,
   output logic signed [W-1:0] out_real,
   output logic signed [W-1:0] out_imag,
   output logic                out_dz,
   output logic                out_sat
);

   localparam logic [W-1:0] HALF = W'(1) << (W - 1);

   typedef struct packed {
      logic         sat;
      logic [W-1:0] val;
   } clip_type;

   logic          valid_ff;
   logic [W-1:0]  real_ff, real_in, imag_ff, imag_in;
   logic          dz_ff, dz_in, sat_ff, sat_in;
   clip_type      re_c, im_c, root_c;

   function automatic clip_type clip(input logic neg, input logic ovf, input logic [W-1:0] q);
      clip_type c;
      c.sat = ovf || (neg ? (q > HALF) : (q > HALF - W'(1)));
      if (c.sat) begin
         c.val = neg ? HALF : HALF - W'(1);
      end else begin
         c.val = neg ? (~q + W'(1)) : q;
      end
      return c;
   endfunction

   always_comb begin
      re_c    = clip(ctl_i.re_neg, ctl_i.re_ovf, re_q_i);
      im_c    = clip(ctl_i.im_neg, ctl_i.im_ovf, im_q_i);
      root_c  = clip(1'b0, 1'b0, root_i);
      real_in = '0;
      imag_in = '0;
      dz_in   = 1'b0;
      sat_in  = 1'b0;
      case (ctl_i.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
            real_in = re_c.val;
            imag_in = im_c.val;
            sat_in  = re_c.sat | im_c.sat;
         end
         cau_pkg::OP_DIV: begin
            if (ctl_i.dz) begin
               dz_in = 1'b1;
            end else begin
               real_in = re_c.val;
               imag_in = im_c.val;
               sat_in  = re_c.sat | im_c.sat;
            end
         end
         cau_pkg::OP_MOD: begin
            real_in = root_c.val;
            sat_in  = root_c.sat;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         real_ff <= real_in;
         imag_ff <= imag_in;
         dz_ff   <= dz_in;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_real  = real_ff;
   assign out_imag  = imag_ff;
   assign out_dz    = dz_ff;
   assign out_sat   = sat_ff;

endmodule

[tb/complex_arithmetic_unit_checker.sv]
`timescale 1ns / 100ps

module complex_arithmetic_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic signed [15:0] req_a_real,
   input  logic signed [15:0] req_a_imag,
   input  logic signed [15:0] req_b_real,
   input  logic signed [15:0] req_b_imag,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_res_real,
   input  logic signed [15:0] rsp_res_imag,
   input  logic               rsp_div_by_zero,
   input  logic               rsp_saturated,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               dz;
      logic               sat;
   } cplx_result_type;

   cplx_result_type result_fifo[$];

   assign pending_count = result_fifo.size();

   // clip a sign/magnitude value to 16 bits
   function automatic logic signed [15:0] clip16(input logic neg,
         input logic [127:0] mag, inout logic sat);
      if (!neg) begin
         if (mag > 128'd32767) begin
            sat = 1'b1;
            return 16'sd32767;
         end
         return mag[15:0];
      end
      if (mag > 128'd32768) begin
         sat = 1'b1;
         return -16'sd32768;
      end
      return -$signed({1'b0, mag[15:0]});
   endfunction

   function automatic logic [127:0] abs128(input logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [127:0] rnd_quot(input logic [127:0] n, input logic [127:0] d);
      logic [127:0] q;
      logic [127:0] r;
      q = (n << 8) / d;
      r = (n << 8) % d;
      if (q >= (128'd1 << 40)) return 128'd1 << 40;
      if (r >= d - r) q = q + 1;
      return q;
   endfunction

   function automatic logic [127:0] int_sqrt(input logic [127:0] v);
      logic [127:0] lo;
      logic [127:0] hi;
      logic [127:0] mid;
      lo = 0;
      hi = 128'd65536;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic cplx_result_type compute_result(input logic [2:0] op,
         input logic signed [15:0] ar, input logic signed [15:0] ai,
         input logic signed [15:0] br, input logic signed [15:0] bi);
      cplx_result_type r;
      logic signed [127:0] xr, xi, yr, yi, s, den;
      logic sat;
      xr = ar; xi = ai; yr = br; yi = bi;
      sat = 1'b0;
      r = '0;
      case (op)
         cau_pkg::OP_ADD: begin
            s = xr + yr; r.re = clip16(s < 0, abs128(s), sat);
            s = xi + yi; r.im = clip16(s < 0, abs128(s), sat);
         end
         cau_pkg::OP_SUB: begin
            s = xr - yr; r.re = clip16(s < 0, abs128(s), sat);
            s = xi - yi; r.im = clip16(s < 0, abs128(s), sat);
         end
         cau_pkg::OP_MUL: begin
            s = xr * yr - xi * yi;
            r.re = clip16(s < 0, (abs128(s) + 128) >> 8, sat);
            s = xr * yi + xi * yr;
            r.im = clip16(s < 0, (abs128(s) + 128) >> 8, sat);
         end
         cau_pkg::OP_DIV: begin
            if (br == 0 && bi == 0) begin
               r.dz = 1'b1;
            end else begin
               den = yr * yr + yi * yi;
               s = xr * yr + xi * yi;
               r.re = clip16(s < 0, rnd_quot(abs128(s), den), sat);
               s = yr * xi - xr * yi;
               r.im = clip16(s < 0, rnd_quot(abs128(s), den), sat);
            end
         end
         cau_pkg::OP_MOD: begin
            r.re = clip16(1'b0, int_sqrt(xr * xr + xi * xi), sat);
         end
         default: ;
      endcase
      r.sat = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      cplx_result_type exp_r;
      if (reset) begin
         result_fifo.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            result_fifo.push_back(compute_result(req_opcode, req_a_real, req_a_imag,
               req_b_real, req_b_imag));
         if (rsp_valid && rsp_ready) begin
            if (result_fifo.size() == 0) begin
               $display("%0t: unexpected transaction re=%0d im=%0d", $time,
                  rsp_res_real, rsp_res_imag);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = result_fifo.pop_front();
               if (exp_r.re !== rsp_res_real || exp_r.im !== rsp_res_imag ||
                     exp_r.dz !== rsp_div_by_zero || exp_r.sat !== rsp_saturated) begin
                  $display("%0t: mismatch expected re=%0d im=%0d dz=%0b sat=%0b",
                     $time, exp_r.re, exp_r.im, exp_r.dz, exp_r.sat);
                  $display("%0t:          actual   re=%0d im=%0d dz=%0b sat=%0b",
                     $time, rsp_res_real, rsp_res_imag, rsp_div_by_zero,
                     rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[tb/complex_arithmetic_unit_tb.sv]
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_opcode;
   logic signed [15:0] req_a_real, req_a_imag, req_b_real, req_b_imag;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_res_real, rsp_res_imag;
   logic               rsp_div_by_zero, rsp_saturated;
   int                 fail_count;
   int                 pending_count;
   int                 send_idle_pct;
   int                 stall_pct;
   int                 hold_off;
   logic               hold_req;
   logic               hold_seen;

   complex_arithmetic_unit dut (.*);

   complex_arithmetic_unit_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_off  <= 0;
         hold_seen <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_off  <= 80;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [15:0] ar,
         input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_a_real <= ar;
      req_a_imag <= ai;
      req_b_real <= br;
      req_b_imag <= bi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(1024)) - 512);
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] v [4];
      logic [2:0]  op;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = cau_pkg::OP_ADD;
      req_a_real = '0; req_a_imag = '0; req_b_real = '0; req_b_imag = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every opcode, zero divisor, unused opcodes
      for (int o = 0; o < 8; o++) begin
         send_item(3'(o), 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
         send_item(3'(o), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      end
      send_item(cau_pkg::OP_DIV, 16'h0100, 16'hff00, 16'h0000, 16'h0000);
      send_item(cau_pkg::OP_DIV, 16'h0300, 16'h0100, 16'h0001, 16'h0000);
      send_item(cau_pkg::OP_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
      send_item(cau_pkg::OP_MUL, 16'h0180, 16'h0000, 16'h0080, 16'h0000);
      send_item(cau_pkg::OP_MOD, 16'h0300, 16'h0400, 16'h0000, 16'h0000);
      send_item(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);

      for (int n = 0; n < 950; n++) begin
         case (n)
            0:   begin send_idle_pct = 0;  stall_pct = 0;  end
            240: begin send_idle_pct = 50; stall_pct = 0;  end
            480: begin send_idle_pct = 0;  stall_pct = 50; end
            720: begin send_idle_pct = 35; stall_pct = 35; end
            default: ;
         endcase
         if (n == 100) hold_req = ~hold_req;
         if (n == 600) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         foreach (v[i]) v[i] = pick_value();
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         if (op == cau_pkg::OP_DIV && $urandom_range(9) == 0) begin
            v[2] = '0; v[3] = '0;
         end
         send_item(op, v[0], v[1], v[2], v[3]);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

[files.f]
+incdir+design
design/cau_pkg.sv
design/cau_front.sv
design/cau_div_step.sv
design/cau_back.sv
design/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_checker.sv
tb/complex_arithmetic_unit_tb.sv
